// ===== design/i32dqr_pkg.sv =====
// shared constants and types for the pipelined 32-bit integer divider
// no dependencies; used by the channel interfaces and every divider module
package i32dqr_pkg;

    // default operand width
    parameter int DATA_W = 32;

    // per-beat sign and exception bits that ride alongside the operands
    typedef struct packed {
        logic neg_quo;   // quotient must be negated at the end
        logic neg_rem;   // remainder must be negated at the end
        logic div_zero;  // divisor was zero
    } t_meta;

endpackage

// ===== design/i32dqr_if.sv =====
// valid/ready channel interfaces for divider requests and responses
// depends on i32dqr_pkg for the default data width
interface i32dqr_req_if #(
    parameter int WIDTH = i32dqr_pkg::DATA_W
);
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [WIDTH-1:0] dividend;
    logic [WIDTH-1:0] divisor;

    modport source (output valid, output cmd, output dividend, output divisor, input ready);
    modport sink   (input valid, input cmd, input dividend, input divisor, output ready);
endinterface

interface i32dqr_rsp_if #(
    parameter int WIDTH = i32dqr_pkg::DATA_W
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] quotient;
    logic [WIDTH-1:0] remainder;
    logic             divide_by_zero;

    modport source (output valid, output quotient, output remainder, output divide_by_zero,
                    input ready);
    modport sink   (input valid, input quotient, input remainder, input divide_by_zero,
                    output ready);
endinterface

// ===== design/i32dqr_pre.sv =====
// input stage: operand magnitudes, sign fixup flags and divide-by-zero detect
// depends on i32dqr_pkg for t_meta
module i32dqr_pre #(
    parameter int WIDTH = i32dqr_pkg::DATA_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_cmd,
    input  logic [WIDTH-1:0]   i_dividend,
    input  logic [WIDTH-1:0]   i_divisor,
    output logic               o_valid,
    input  logic               i_ready,
    output i32dqr_pkg::t_meta  o_meta,
    output logic [WIDTH-1:0]   o_num,
    output logic [WIDTH-1:0]   o_den
);

    logic              a_neg;
    logic              b_neg;
    logic [WIDTH-1:0]  n_num;
    logic [WIDTH-1:0]  n_den;
    i32dqr_pkg::t_meta n_meta;
    logic              r_valid;
    logic [WIDTH-1:0]  r_num;
    logic [WIDTH-1:0]  r_den;
    i32dqr_pkg::t_meta r_meta;

    // signs only count in signed mode
    assign a_neg = i_cmd & i_dividend[WIDTH-1];
    assign b_neg = i_cmd & i_divisor[WIDTH-1];

    // magnitudes and end-of-pipe fixups
    always_comb begin
        n_num           = a_neg ? (-i_dividend) : i_dividend;
        n_den           = b_neg ? (-i_divisor) : i_divisor;
        n_meta.neg_quo  = a_neg ^ b_neg;
        n_meta.neg_rem  = a_neg;
        n_meta.div_zero = (i_divisor == '0);
    end

    assign o_ready = !r_valid || i_ready;

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_num  <= n_num;
            r_den  <= n_den;
            r_meta <= n_meta;
        end
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_meta  = r_meta;

endmodule

// ===== design/i32dqr_step.sv =====
// one restoring-division stage: resolves one quotient bit per beat
// depends on i32dqr_pkg for t_meta
module i32dqr_step #(
    parameter int WIDTH = i32dqr_pkg::DATA_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  i32dqr_pkg::t_meta  i_meta,
    input  logic [WIDTH-1:0]   i_nq,
    input  logic [WIDTH-1:0]   i_den,
    input  logic [WIDTH-1:0]   i_rem,
    output logic               o_valid,
    input  logic               i_ready,
    output i32dqr_pkg::t_meta  o_meta,
    output logic [WIDTH-1:0]   o_nq,
    output logic [WIDTH-1:0]   o_den,
    output logic [WIDTH-1:0]   o_rem
);

    // i_nq holds the unused dividend bits on top and the quotient bits so far below
    logic [WIDTH:0]    shifted;
    logic [WIDTH:0]    diff;
    logic              take;
    logic [WIDTH-1:0]  n_rem;
    logic [WIDTH-1:0]  n_nq;
    logic              r_valid;
    i32dqr_pkg::t_meta r_meta;
    logic [WIDTH-1:0]  r_nq;
    logic [WIDTH-1:0]  r_den;
    logic [WIDTH-1:0]  r_rem;

    // shift in the next dividend bit, trial subtract, restore on borrow
    always_comb begin
        shifted = {i_rem, i_nq[WIDTH-1]};
        diff    = shifted - {1'b0, i_den};
        take    = !diff[WIDTH];
        n_rem   = take ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
        n_nq    = {i_nq[WIDTH-2:0], take};
    end

    assign o_ready = !r_valid || i_ready;

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_meta <= i_meta;
            r_nq   <= n_nq;
            r_den  <= i_den;
            r_rem  <= n_rem;
        end
    end

    assign o_valid = r_valid;
    assign o_meta  = r_meta;
    assign o_nq    = r_nq;
    assign o_den   = r_den;
    assign o_rem   = r_rem;

endmodule

// ===== design/i32dqr_post.sv =====
// output stage: sign correction, divide-by-zero zeroing and the result register
// depends on i32dqr_pkg for t_meta
module i32dqr_post #(
    parameter int WIDTH = i32dqr_pkg::DATA_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  i32dqr_pkg::t_meta  i_meta,
    input  logic [WIDTH-1:0]   i_quo,
    input  logic [WIDTH-1:0]   i_rem,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [WIDTH-1:0]   o_quotient,
    output logic [WIDTH-1:0]   o_remainder,
    output logic               o_divide_by_zero
);

    logic [WIDTH-1:0] n_quo;
    logic [WIDTH-1:0] n_rem;
    logic             r_valid;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_rem;
    logic             r_dbz;

    // apply signs; zero divisor forces both results to zero
    always_comb begin
        if (i_meta.div_zero) begin
            n_quo = '0;
            n_rem = '0;
        end else begin
            n_quo = i_meta.neg_quo ? (-i_quo) : i_quo;
            n_rem = i_meta.neg_rem ? (-i_rem) : i_rem;
        end
    end

    assign o_ready = !r_valid || i_ready;

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
            r_dbz <= i_meta.div_zero;
        end
    end

    assign o_valid          = r_valid;
    assign o_quotient       = r_quo;
    assign o_remainder      = r_rem;
    assign o_divide_by_zero = r_dbz;

endmodule

// ===== design/int32_divide_quotient_remainder.sv =====
// top level of the pipelined integer divider, quotient and remainder
// depends on i32dqr_pkg, i32dqr_if, i32dqr_pre, i32dqr_step and i32dqr_post
//
// usage:
//   requests arrive on i_req (cmd 0 unsigned, 1 signed; dividend; divisor),
//   results leave on o_rsp (quotient, remainder, divide_by_zero), one per request,
//   in request order. a beat moves when valid and ready are both high.
//   signed quotients truncate toward zero, the remainder takes the dividend's
//   sign, the most negative value over minus one wraps, and a zero divisor
//   gives zero quotient and remainder with divide_by_zero set.
// timing:
//   WIDTH + 2 register stages: one operand stage, one restoring stage per
//   quotient bit, one sign-fix/output stage. throughput is one beat per cycle
//   while o_rsp.ready stays high; each stage holds its own valid bit and takes
//   a new beat whenever it is empty or drains.
// reset and stall:
//   synchronous active-low reset empties every stage; no results are pending.
//   when o_rsp.ready is low the full stages hold, empty stages keep filling,
//   and i_req.ready drops only once every stage is occupied.
module int32_divide_quotient_remainder #(
    parameter int WIDTH = i32dqr_pkg::DATA_W
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i32dqr_req_if.sink  i_req,
    i32dqr_rsp_if.source o_rsp
);

    // inter-stage buses, index k feeds step k
    logic              s_valid [0:WIDTH];
    logic              s_ready [0:WIDTH];
    i32dqr_pkg::t_meta s_meta  [0:WIDTH];
    logic [WIDTH-1:0]  s_nq    [0:WIDTH];
    logic [WIDTH-1:0]  s_den   [0:WIDTH];
    logic [WIDTH-1:0]  s_rem   [0:WIDTH];

    // operand stage
    i32dqr_pre #(.WIDTH(WIDTH)) u_pre (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_req.valid),
        .o_ready    (i_req.ready),
        .i_cmd      (i_req.cmd),
        .i_dividend (i_req.dividend),
        .i_divisor  (i_req.divisor),
        .o_valid    (s_valid[0]),
        .i_ready    (s_ready[0]),
        .o_meta     (s_meta[0]),
        .o_num      (s_nq[0]),
        .o_den      (s_den[0])
    );

    // partial remainder starts at zero
    assign s_rem[0] = '0;

    // one restoring stage per quotient bit, msb first
    for (genvar k = 0; k < WIDTH; k++) begin : g_step
        i32dqr_step #(.WIDTH(WIDTH)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[k]),
            .o_ready (s_ready[k]),
            .i_meta  (s_meta[k]),
            .i_nq    (s_nq[k]),
            .i_den   (s_den[k]),
            .i_rem   (s_rem[k]),
            .o_valid (s_valid[k+1]),
            .i_ready (s_ready[k+1]),
            .o_meta  (s_meta[k+1]),
            .o_nq    (s_nq[k+1]),
            .o_den   (s_den[k+1]),
            .o_rem   (s_rem[k+1])
        );
    end

    // sign fix and result register
    i32dqr_post #(.WIDTH(WIDTH)) u_post (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_valid[WIDTH]),
        .o_ready          (s_ready[WIDTH]),
        .i_meta           (s_meta[WIDTH]),
        .i_quo            (s_nq[WIDTH]),
        .i_rem            (s_rem[WIDTH]),
        .o_valid          (o_rsp.valid),
        .i_ready          (o_rsp.ready),
        .o_quotient       (o_rsp.quotient),
        .o_remainder      (o_rsp.remainder),
        .o_divide_by_zero (o_rsp.divide_by_zero)
    );

endmodule

// ===== bench/tb.sv =====
// self-checking bench for int32_divide_quotient_remainder, unsigned and signed division
// depends on i32dqr_pkg, i32dqr_if and the divider rtl; a class predicts and checks each beat
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = i32dqr_pkg::DATA_W;

    // division mode carried on cmd
    localparam logic CMD_UNSIGNED = 1'b0;
    localparam logic CMD_SIGNED   = 1'b1;

    // number of random beats in each idling phase
    localparam int PHASE_BEATS = 283;

    typedef struct packed {
        logic [W-1:0] quotient;
        logic [W-1:0] remainder;
        logic         divide_by_zero;
    } t_div_result;

    // predicts each division and checks responses in request order
    class t_quo_rem_ledger;
        t_div_result owed_results[$];
        int          mismatches;

        function new();
            mismatches = 0;
        endfunction

        // bit-serial restoring division of two magnitudes
        function automatic t_div_result divide_magnitudes(logic [W-1:0] num, logic [W-1:0] den);
            logic [W:0]  part;
            t_div_result res;
            part = '0;
            res  = '0;
            for (int i = W - 1; i >= 0; i--) begin
                part = {part[W-1:0], num[i]};
                res.quotient = res.quotient << 1;
                if (part >= {1'b0, den}) begin
                    part = part - {1'b0, den};
                    res.quotient[0] = 1'b1;
                end
            end
            res.remainder = part[W-1:0];
            return res;
        endfunction

        function automatic t_div_result expected_division(logic cmd, logic [W-1:0] a,
                                                          logic [W-1:0] b);
            t_div_result res;
            logic        a_neg;
            logic        b_neg;
            res   = '0;
            a_neg = (cmd == CMD_SIGNED) && a[W-1];
            b_neg = (cmd == CMD_SIGNED) && b[W-1];
            // zero divisor gives zero quotient and remainder with the flag set
            if (b == '0) begin
                res.divide_by_zero = 1'b1;
                return res;
            end
            res = divide_magnitudes(a_neg ? -a : a, b_neg ? -b : b);
            // quotient truncates toward zero, remainder follows the dividend
            if (a_neg != b_neg)
                res.quotient = -res.quotient;
            if (a_neg)
                res.remainder = -res.remainder;
            return res;
        endfunction

        function void note_request(logic cmd, logic [W-1:0] a, logic [W-1:0] b);
            owed_results.push_back(expected_division(cmd, a, b));
        endfunction

        function void check_response(logic [W-1:0] q, logic [W-1:0] r, logic dz);
            t_div_result exp_res;
            if (owed_results.size() == 0) begin
                $error("response beat with nothing outstanding: q=%h r=%h dz=%b", q, r, dz);
                mismatches++;
                return;
            end
            exp_res = owed_results.pop_front();
            if (q !== exp_res.quotient) begin
                $error("quotient: expected %h, got %h", exp_res.quotient, q);
                mismatches++;
            end
            if (r !== exp_res.remainder) begin
                $error("remainder: expected %h, got %h", exp_res.remainder, r);
                mismatches++;
            end
            if (dz !== exp_res.divide_by_zero) begin
                $error("divide_by_zero: expected %b, got %b", exp_res.divide_by_zero, dz);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return owed_results.size();
        endfunction
    endclass

    logic            i_clk;
    logic            i_rst_n;
    int              send_idle_pct;
    int              recv_idle_pct;
    t_quo_rem_ledger ledger;

    i32dqr_req_if #(.WIDTH(W)) req_bus ();
    i32dqr_rsp_if #(.WIDTH(W)) rsp_bus ();

    int32_divide_quotient_remainder #(.WIDTH(W)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // receiver backpressure, redrawn every cycle
    always @(negedge i_clk) begin
        rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // check every response beat
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready)
            ledger.check_response(rsp_bus.quotient, rsp_bus.remainder, rsp_bus.divide_by_zero);
    end

    // drive one request beat, with random idle cycles ahead of it
    task automatic send_division(input logic cmd, input logic [W-1:0] a, input logic [W-1:0] b);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.cmd      <= cmd;
        req_bus.dividend <= a;
        req_bus.divisor  <= b;
        @(posedge i_clk);
        while (!req_bus.ready)
            @(posedge i_clk);
        ledger.note_request(cmd, a, b);
        @(negedge i_clk);
    endtask

    // hold off the sender until every outstanding result has come back
    task automatic drain_pipeline();
        req_bus.valid <= 1'b0;
        while (ledger.outstanding() != 0)
            @(negedge i_clk);
    endtask

    // operand mix: wide random, short values, boundary patterns, small negatives, near most negative
    function automatic logic [W-1:0] random_operand();
        logic [W-1:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom;
            4, 5:       v = $urandom >> $urandom_range(W - 1);
            6:          v = $urandom_range(16);
            7: begin
                case ($urandom_range(4))
                    0: v = '0;
                    1: v = 1;
                    2: v = '1;
                    3: v = {1'b1, {(W-1){1'b0}}};
                    default: v = {1'b0, {(W-1){1'b1}}};
                endcase
            end
            8:          v = -$urandom_range(16);
            default:    v = {1'b1, {(W-1){1'b0}}} | $urandom_range(3);
        endcase
        return v;
    endfunction

    // run limit
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // main sequence
    initial begin
        ledger           = new();
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        req_bus.valid    = 1'b0;
        req_bus.cmd      = CMD_UNSIGNED;
        req_bus.dividend = '0;
        req_bus.divisor  = '0;
        rsp_bus.ready    = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: unsigned extremes and zero divisor
        send_division(CMD_UNSIGNED, '0, 1);
        send_division(CMD_UNSIGNED, '1, 1);
        send_division(CMD_UNSIGNED, '1, '1);
        send_division(CMD_UNSIGNED, 7, '1);
        send_division(CMD_UNSIGNED, 32'h1234_5678, '0);
        send_division(CMD_UNSIGNED, '1, '0);
        send_division(CMD_UNSIGNED, 100, 7);
        send_division(CMD_UNSIGNED, 32'h8000_0000, 2);
        // directed: signed zero divisor, most negative over minus one, sign combinations
        send_division(CMD_SIGNED, '0, '0);
        send_division(CMD_SIGNED, '1, '0);
        send_division(CMD_SIGNED, 32'h8000_0000, '1);
        send_division(CMD_SIGNED, 32'h8000_0000, 1);
        send_division(CMD_SIGNED, 32'h8000_0000, 32'h8000_0000);
        send_division(CMD_SIGNED, 32'h8000_0000, 7);
        send_division(CMD_SIGNED, 32'h7fff_ffff, 32'h8000_0000);
        send_division(CMD_SIGNED, 32'h7fff_ffff, '1);
        send_division(CMD_SIGNED, 1, 32'h8000_0000);
        send_division(CMD_SIGNED, 7, 2);
        send_division(CMD_SIGNED, -7, 2);
        send_division(CMD_SIGNED, 7, -2);
        send_division(CMD_SIGNED, -7, -2);
        drain_pipeline();

        // random beats under three idling patterns
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 73 : 0;
            recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 9 : 0;
            for (int n = 0; n < PHASE_BEATS; n++)
                send_division(1'($urandom_range(1)), random_operand(), random_operand());
        end
        req_bus.valid <= 1'b0;

        // wait for the last results, then watch for strays
        while (ledger.outstanding() != 0)
            @(posedge i_clk);
        repeat (2 * W + 8) @(posedge i_clk);

        if (ledger.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
